### hdl/sgce_pkg.sv
`timescale 1ns / 1ps
package sgce_pkg;

  localparam int POINTS_MAX = 2048;
  localparam int FOUND_MAX  = 64;
  localparam int FIFO_DEPTH = 4;

  localparam int COORD_W = 16;
  localparam int CNT_W   = $clog2(POINTS_MAX + 1);
  localparam int ADDR_W  = $clog2(POINTS_MAX);
  localparam int TOT_W   = $clog2(FOUND_MAX + 1);
  localparam int TBL_AW  = (FOUND_MAX > 1) ? $clog2(FOUND_MAX) : 1;
  localparam int SUM_W   = COORD_W + CNT_W;
  localparam int DSTEP_W = $clog2(SUM_W);
  localparam int D2_W    = 34;
  localparam int RAD_W   = 17;
  localparam int BIT_W   = $clog2(RAD_W);
  localparam int PCNT_W  = 12;

  localparam logic [1:0] REG_GAP   = 2'd0;
  localparam logic [1:0] REG_MINP  = 2'd1;
  localparam logic [1:0] REG_MAXC  = 2'd2;
  localparam logic [1:0] REG_MAXR  = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pt_t;

  typedef struct packed {
    pt_t  pt;
    logic brk;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          rad;
    logic [CNT_W-1:0]          cnt;
  } clus_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RAD_W-1:0]          rad;
    logic [PCNT_W-1:0]         cnt;
    logic                      last;
    logic                      ovf;
  } res_t;

  typedef struct packed {
    logic [15:0] gap;
    logic [11:0] minp;
    logic [6:0]  maxc;
    logic [15:0] maxr;
  } cfg_t;

  typedef enum logic [2:0] {F_IDLE, F_SQX, F_SQY, F_GAP, F_PUSH} front_st_t;

  typedef enum logic [4:0] {
    B_IDLE, B_CHK, B_SUM_RD, B_SUM_ACC, B_DIV_INIT, B_DIV, B_DIV_END,
    B_MX_RD, B_MX_SQX, B_MX_SQY, B_MX_CMP, B_SQRT, B_KEEP, B_STORE,
    B_EM_INIT, B_SEL_RD, B_SEL_CMP, B_OUT_RD, B_OUT, B_EMPTY
  } back_st_t;

endpackage

### hdl/sgce_if.sv
`timescale 1ns / 1ps
interface sgce_in_if;
  import sgce_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_mm;
  logic signed [COORD_W-1:0] y_mm;
  logic                      last_point;
  modport source (output valid, x_mm, y_mm, last_point, input ready);
  modport sink (input valid, x_mm, y_mm, last_point, output ready);
endinterface

interface sgce_out_if;
  import sgce_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cluster_valid;
  logic signed [COORD_W-1:0] center_x_mm;
  logic signed [COORD_W-1:0] center_y_mm;
  logic [RAD_W-1:0]          radius_mm;
  logic [PCNT_W-1:0]         point_count;
  logic                      last_cluster;
  logic                      overflow;
  modport source (output valid, cluster_valid, center_x_mm, center_y_mm, radius_mm,
                  point_count, last_cluster, overflow, input ready);
  modport sink (input valid, cluster_valid, center_x_mm, center_y_mm, radius_mm,
                point_count, last_cluster, overflow, output ready);
endinterface

### hdl/sgce_front.sv
`timescale 1ns / 1ps
module sgce_front (
  input  logic          clk,
  input  logic          rst_n,
  sgce_in_if.sink       in_pt,
  input  logic [15:0]   gap_mm,
  output sgce_pkg::cmd_t push_data,
  output logic          push_valid,
  input  logic          push_ready
);
  import sgce_pkg::*;

  front_st_t st_r, st_nxt;
  logic signed [COORD_W-1:0] x_r, y_r, px_r, py_r;
  logic signed [COORD_W:0]   dx_r, dy_r;
  logic [D2_W-1:0]           sqx_r, sqy_r;
  logic [31:0]               gsq_r;
  logic                      last_r, have_r;
  logic [D2_W:0]             d2;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: if (in_pt.valid) st_nxt = F_SQX;
      F_SQX:  st_nxt = F_SQY;
      F_SQY:  st_nxt = F_GAP;
      F_GAP:  st_nxt = F_PUSH;
      F_PUSH: if (push_ready) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  assign d2 = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    in_pt.ready       = (st_r == F_IDLE);
    push_valid        = (st_r == F_PUSH);
    push_data.pt.x    = x_r;
    push_data.pt.y    = y_r;
    push_data.last    = last_r;
    push_data.brk     = have_r && (d2 > {{(D2_W - 31){1'b0}}, gsq_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      have_r <= 1'b0;
      px_r   <= '0;
      py_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == F_PUSH && push_ready) begin
        px_r   <= x_r;
        py_r   <= y_r;
        have_r <= !last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: begin
        x_r    <= in_pt.x_mm;
        y_r    <= in_pt.y_mm;
        last_r <= in_pt.last_point;
        dx_r   <= {in_pt.x_mm[COORD_W-1], in_pt.x_mm} - {px_r[COORD_W-1], px_r};
        dy_r   <= {in_pt.y_mm[COORD_W-1], in_pt.y_mm} - {py_r[COORD_W-1], py_r};
      end
      F_SQX: sqx_r <= D2_W'(dx_r * dx_r);
      F_SQY: sqy_r <= D2_W'(dy_r * dy_r);
      F_GAP: gsq_r <= 32'(gap_mm * gap_mm);
      default: ;
    endcase
  end

endmodule

### hdl/sgce_fifo.sv
`timescale 1ns / 1ps
module sgce_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  sgce_pkg::cmd_t wr_data,
  input  logic           wr_valid,
  output logic           wr_ready,
  output sgce_pkg::cmd_t rd_data,
  output logic           rd_valid,
  input  logic           rd_pop
);
  import sgce_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t            mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;
  logic            do_wr, do_rd;

  assign wr_ready = (cnt_r != (PW + 1)'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= PW'((wp_r + 1'b1) % FIFO_DEPTH);
      if (do_rd) rp_r <= PW'((rp_r + 1'b1) % FIFO_DEPTH);
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

### hdl/sgce_back.sv
`timescale 1ns / 1ps
module sgce_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sgce_pkg::cfg_t cfg,
  input  sgce_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output sgce_pkg::res_t res,
  output logic           res_valid,
  input  logic           res_ready
);
  import sgce_pkg::*;

  back_st_t st_r, st_nxt;

  cmd_t                      cur_r, cur_nxt;
  logic                      fin_r, fin_nxt;
  logic [CNT_W-1:0]          seglen_r, seglen_nxt;
  logic [TOT_W-1:0]          total_r, total_nxt;
  logic                      drop_r, drop_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic signed [SUM_W-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SUM_W-1:0]          qx_r, qx_nxt, qy_r, qy_nxt;
  logic [CNT_W:0]            rx_r, rx_nxt, ry_r, ry_nxt;
  logic [DSTEP_W-1:0]        dstep_r, dstep_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [D2_W-1:0]           sqx_r, sqx_nxt, sqy_r, sqy_nxt, best_r, best_nxt;
  logic [RAD_W-1:0]          root_r, root_nxt;
  logic [BIT_W-1:0]          bi_r, bi_nxt;
  logic [TOT_W-1:0]          k_r, k_nxt, emit_r, emit_nxt, tidx_r, tidx_nxt;
  logic [TBL_AW-1:0]         pick_r, pick_nxt;
  logic [CNT_W-1:0]          pcnt_r, pcnt_nxt;
  logic                      have_r, have_nxt, sel_r, sel_nxt;
  logic [FOUND_MAX-1:0]      used_r, used_nxt;
  res_t                      out_r, out_nxt;
  logic                      ovld_r, ovld_nxt;

  pt_t                       seg_mem [POINTS_MAX];
  pt_t                       seg_rd_r;
  clus_t                     tbl_mem [FOUND_MAX];
  clus_t                     tbl_rd_r;

  logic                      seg_we, seg_re, tbl_we, tbl_re;
  logic [ADDR_W-1:0]         seg_waddr, seg_raddr;
  logic [TBL_AW-1:0]         tbl_waddr, tbl_raddr;
  clus_t                     tbl_wdata;

  // Shared combinational terms.
  logic [11:0]               need;
  logic                      too_short, out_free, sel_win, drop_keep, reject;
  logic [31:0]               cap;
  logic [CNT_W:0]            rsx, rsy;
  logic                      gex, gey;
  logic signed [COORD_W:0]   dmx;
  logic [RAD_W-1:0]          cand;
  logic [D2_W:0]             d2;

  always_comb begin
    need      = (cfg.minp == '0) ? 12'd1 : cfg.minp;
    too_short = (seglen_r == '0) || (32'(seglen_r) < 32'(need));
    cap       = (cfg.maxc == '0) ? 32'd1 : 32'(cfg.maxc);
    out_free  = !ovld_r || res_ready;
    sel_win   = !used_r[tidx_r[TBL_AW-1:0]] && (!have_r || tbl_rd_r.cnt > pcnt_r);
    reject    = (cfg.maxr != '0) && (root_r > {1'b0, cfg.maxr});
    drop_keep = (32'(total_r) >= 32'(FOUND_MAX));
    rsx       = {rx_r[CNT_W-1:0], qx_r[SUM_W-1]};
    rsy       = {ry_r[CNT_W-1:0], qy_r[SUM_W-1]};
    gex       = rsx >= {1'b0, seglen_r};
    gey       = rsy >= {1'b0, seglen_r};
    dmx       = (st_r == B_MX_SQX)
                ? {seg_rd_r.x[COORD_W-1], seg_rd_r.x} - {cx_r[COORD_W-1], cx_r}
                : {seg_rd_r.y[COORD_W-1], seg_rd_r.y} - {cy_r[COORD_W-1], cy_r};
    cand      = root_r | (RAD_W'(1) << bi_r);
    d2        = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE:     if (cmd_valid) st_nxt = cmd.brk ? B_CHK : B_STORE;
      B_CHK:      if (too_short) st_nxt = fin_r ? B_EM_INIT : B_STORE;
                  else st_nxt = B_SUM_RD;
      B_SUM_RD:   st_nxt = B_SUM_ACC;
      B_SUM_ACC:  st_nxt = (idx_r + 1'b1 == seglen_r) ? B_DIV_INIT : B_SUM_RD;
      B_DIV_INIT: st_nxt = B_DIV;
      B_DIV:      if (dstep_r == DSTEP_W'(SUM_W - 1)) st_nxt = B_DIV_END;
      B_DIV_END:  st_nxt = B_MX_RD;
      B_MX_RD:    st_nxt = B_MX_SQX;
      B_MX_SQX:   st_nxt = B_MX_SQY;
      B_MX_SQY:   st_nxt = B_MX_CMP;
      B_MX_CMP:   st_nxt = (idx_r + 1'b1 == seglen_r) ? B_SQRT : B_MX_RD;
      B_SQRT:     if (bi_r == '0) st_nxt = B_KEEP;
      B_KEEP:     st_nxt = fin_r ? B_EM_INIT : B_STORE;
      B_STORE:    st_nxt = cur_r.last ? B_CHK : B_IDLE;
      B_EM_INIT: begin
        if (total_r == '0) st_nxt = B_EMPTY;
        else if (32'(total_r) <= cap) st_nxt = B_OUT_RD;
        else st_nxt = B_SEL_RD;
      end
      B_SEL_RD:   st_nxt = B_SEL_CMP;
      B_SEL_CMP:  st_nxt = (tidx_r + 1'b1 == total_r) ? B_OUT_RD : B_SEL_RD;
      B_OUT_RD:   st_nxt = B_OUT;
      B_OUT: begin
        if (out_free) begin
          if (k_r + 1'b1 == emit_r) st_nxt = B_IDLE;
          else st_nxt = sel_r ? B_SEL_RD : B_OUT_RD;
        end
      end
      B_EMPTY:    if (out_free) st_nxt = B_IDLE;
      default:    st_nxt = B_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cur_nxt = cur_r;       fin_nxt = fin_r;       seglen_nxt = seglen_r;
    total_nxt = total_r;   drop_nxt = drop_r;     idx_nxt = idx_r;
    sx_nxt = sx_r;         sy_nxt = sy_r;         qx_nxt = qx_r;
    qy_nxt = qy_r;         rx_nxt = rx_r;         ry_nxt = ry_r;
    dstep_nxt = dstep_r;   cx_nxt = cx_r;         cy_nxt = cy_r;
    sqx_nxt = sqx_r;       sqy_nxt = sqy_r;       best_nxt = best_r;
    root_nxt = root_r;     bi_nxt = bi_r;         k_nxt = k_r;
    emit_nxt = emit_r;     tidx_nxt = tidx_r;     pick_nxt = pick_r;
    pcnt_nxt = pcnt_r;     have_nxt = have_r;     sel_nxt = sel_r;
    used_nxt = used_r;     out_nxt = out_r;
    ovld_nxt = ovld_r && !res_ready;
    cmd_pop = 1'b0;
    seg_we = 1'b0;  seg_waddr = seglen_r[ADDR_W-1:0];
    seg_re = 1'b0;  seg_raddr = idx_r[ADDR_W-1:0];
    tbl_we = 1'b0;  tbl_waddr = total_r[TBL_AW-1:0];
    tbl_re = 1'b0;  tbl_raddr = tidx_r[TBL_AW-1:0];
    tbl_wdata = '{cx: cx_r, cy: cy_r, rad: root_r, cnt: seglen_r};

    case (st_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          fin_nxt = 1'b0;
        end
      end
      B_CHK: begin
        idx_nxt = '0;
        sx_nxt  = '0;
        sy_nxt  = '0;
        if (too_short) seglen_nxt = '0;
      end
      B_SUM_RD: seg_re = 1'b1;
      B_SUM_ACC: begin
        sx_nxt  = sx_r + {{(SUM_W - COORD_W){seg_rd_r.x[COORD_W-1]}}, seg_rd_r.x};
        sy_nxt  = sy_r + {{(SUM_W - COORD_W){seg_rd_r.y[COORD_W-1]}}, seg_rd_r.y};
        idx_nxt = idx_r + 1'b1;
      end
      B_DIV_INIT: begin
        // Divide magnitudes, restore the sign afterward (truncation toward zero).
        qx_nxt    = sx_r[SUM_W-1] ? SUM_W'(-sx_r) : SUM_W'(sx_r);
        qy_nxt    = sy_r[SUM_W-1] ? SUM_W'(-sy_r) : SUM_W'(sy_r);
        rx_nxt    = '0;
        ry_nxt    = '0;
        dstep_nxt = '0;
      end
      B_DIV: begin
        qx_nxt    = {qx_r[SUM_W-2:0], gex};
        qy_nxt    = {qy_r[SUM_W-2:0], gey};
        rx_nxt    = gex ? rsx - {1'b0, seglen_r} : rsx;
        ry_nxt    = gey ? rsy - {1'b0, seglen_r} : rsy;
        dstep_nxt = dstep_r + 1'b1;
      end
      B_DIV_END: begin
        cx_nxt   = sx_r[SUM_W-1] ? COORD_W'(-qx_r) : COORD_W'(qx_r);
        cy_nxt   = sy_r[SUM_W-1] ? COORD_W'(-qy_r) : COORD_W'(qy_r);
        idx_nxt  = '0;
        best_nxt = '0;
      end
      B_MX_RD:  seg_re = 1'b1;
      B_MX_SQX: sqx_nxt = D2_W'(dmx * dmx);
      B_MX_SQY: sqy_nxt = D2_W'(dmx * dmx);
      B_MX_CMP: begin
        if (d2 > {1'b0, best_r}) best_nxt = D2_W'(d2);
        idx_nxt  = idx_r + 1'b1;
        root_nxt = '0;
        bi_nxt   = BIT_W'(RAD_W - 1);
      end
      B_SQRT: begin
        if (D2_W'(cand * cand) <= best_r) root_nxt = cand;
        bi_nxt = bi_r - 1'b1;
      end
      B_KEEP: begin
        seglen_nxt = '0;
        if (!reject) begin
          if (drop_keep) drop_nxt = 1'b1;
          else begin
            tbl_we    = 1'b1;
            total_nxt = total_r + 1'b1;
          end
        end
      end
      B_STORE: begin
        if (32'(seglen_r) < 32'(POINTS_MAX)) begin
          seg_we     = 1'b1;
          seglen_nxt = seglen_r + 1'b1;
        end else begin
          drop_nxt = 1'b1;
        end
        if (cur_r.last) fin_nxt = 1'b1;
      end
      B_EM_INIT: begin
        k_nxt    = '0;
        tidx_nxt = '0;
        pick_nxt = '0;
        have_nxt = 1'b0;
        used_nxt = '0;
        if (32'(total_r) <= cap) begin
          sel_nxt  = 1'b0;
          emit_nxt = total_r;
        end else begin
          sel_nxt  = 1'b1;
          emit_nxt = TOT_W'(cap);
        end
      end
      B_SEL_RD: tbl_re = 1'b1;
      B_SEL_CMP: begin
        if (sel_win) begin
          pick_nxt = tidx_r[TBL_AW-1:0];
          pcnt_nxt = tbl_rd_r.cnt;
          have_nxt = 1'b1;
        end
        tidx_nxt = tidx_r + 1'b1;
      end
      B_OUT_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = pick_r;
      end
      B_OUT: begin
        if (out_free) begin
          ovld_nxt = 1'b1;
          out_nxt  = '{valid: 1'b1, cx: tbl_rd_r.cx, cy: tbl_rd_r.cy,
                       rad: tbl_rd_r.rad, cnt: PCNT_W'(tbl_rd_r.cnt),
                       last: (k_r + 1'b1 == emit_r), ovf: drop_r};
          used_nxt[pick_r] = 1'b1;
          k_nxt    = k_r + 1'b1;
          tidx_nxt = '0;
          have_nxt = 1'b0;
          if (!sel_r) pick_nxt = TBL_AW'(k_r + 1'b1);
          if (k_r + 1'b1 == emit_r) begin
            seglen_nxt = '0;
            total_nxt  = '0;
            drop_nxt   = 1'b0;
          end
        end
      end
      B_EMPTY: begin
        if (out_free) begin
          ovld_nxt   = 1'b1;
          out_nxt    = '{valid: 1'b0, cx: '0, cy: '0, rad: '0, cnt: '0,
                         last: 1'b1, ovf: drop_r};
          seglen_nxt = '0;
          total_nxt  = '0;
          drop_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res       = out_r;
  assign res_valid = ovld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      fin_r    <= 1'b0;
      seglen_r <= '0;
      total_r  <= '0;
      drop_r   <= 1'b0;
      ovld_r   <= 1'b0;
      used_r   <= '0;
    end else begin
      st_r     <= st_nxt;
      fin_r    <= fin_nxt;
      seglen_r <= seglen_nxt;
      total_r  <= total_nxt;
      drop_r   <= drop_nxt;
      ovld_r   <= ovld_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;   idx_r  <= idx_nxt;   sx_r   <= sx_nxt;    sy_r   <= sy_nxt;
    qx_r   <= qx_nxt;    qy_r   <= qy_nxt;    rx_r   <= rx_nxt;    ry_r   <= ry_nxt;
    dstep_r <= dstep_nxt; cx_r  <= cx_nxt;    cy_r   <= cy_nxt;    sqx_r  <= sqx_nxt;
    sqy_r  <= sqy_nxt;   best_r <= best_nxt;  root_r <= root_nxt;  bi_r   <= bi_nxt;
    k_r    <= k_nxt;     emit_r <= emit_nxt;  tidx_r <= tidx_nxt;  pick_r <= pick_nxt;
    pcnt_r <= pcnt_nxt;  have_r <= have_nxt;  sel_r  <= sel_nxt;   out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_waddr] <= cur_r.pt;
    if (seg_re) seg_rd_r <= seg_mem[seg_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rd_r <= tbl_mem[tbl_raddr];
  end

endmodule

### hdl/scan_gap_cluster_extractor.sv
`timescale 1ns / 1ps
// Channel  Dir  Word
// in_pt    in   x_mm, y_mm, last_point (one scan point)
// out_cl   out  cluster_valid, center, radius_mm, point_count, last_cluster, overflow
// cfg_*    in   register write: cfg_we, cfg_idx, cfg_wdata
//
// The front end accepts a point, forms the two squared steps and the squared gap one at
// a time, then hands the point to the queue; it takes the next point only after that
// hand-off. The back end stores each point and closes a segment with a sum pass, a
// shift-subtract divide, a distance pass and a bit-wise square root, plus checks. Each
// word is read from the cluster table and emitted; when the size cap applies, a selection
// pass over the table comes before each word. Reset is synchronous and active low; it
// clears all scan state and loads the register defaults. Either side may stall; a four-word queue decouples them.
module scan_gap_cluster_extractor (
  input  logic        clk,
  input  logic        rst_n,
  sgce_in_if.sink     in_pt,
  sgce_out_if.source  out_cl,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);
  import sgce_pkg::*;

  cfg_t cfg_r;
  cmd_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop;
  res_t res;

  // Configuration registers. Writes must only arrive while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap  <= 16'd300;
      cfg_r.minp <= 12'd3;
      cfg_r.maxc <= 7'd10;
      cfg_r.maxr <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAP:  cfg_r.gap  <= cfg_wdata;
        REG_MINP: cfg_r.minp <= cfg_wdata[11:0];
        REG_MAXC: cfg_r.maxc <= cfg_wdata[6:0];
        REG_MAXR: cfg_r.maxr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The front end classifies each point as continuing or breaking a segment.
  sgce_front u_front (
    .clk, .rst_n, .in_pt, .gap_mm(cfg_r.gap),
    .push_data, .push_valid, .push_ready
  );

  sgce_fifo u_fifo (
    .clk, .rst_n,
    .wr_data(push_data), .wr_valid(push_valid), .wr_ready(push_ready),
    .rd_data(pop_data), .rd_valid(pop_valid), .rd_pop(pop)
  );

  // The back end buffers segments, measures clusters and emits the results.
  sgce_back u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .cmd(pop_data), .cmd_valid(pop_valid), .cmd_pop(pop),
    .res, .res_valid(out_cl.valid), .res_ready(out_cl.ready)
  );

  assign out_cl.cluster_valid = res.valid;
  assign out_cl.center_x_mm   = res.cx;
  assign out_cl.center_y_mm   = res.cy;
  assign out_cl.radius_mm     = res.rad;
  assign out_cl.point_count   = res.cnt;
  assign out_cl.last_cluster  = res.last;
  assign out_cl.overflow      = res.ovf;

endmodule

### sim/tb_scan_gap_cluster_extractor.sv
`timescale 1ns / 1ps
// Testbench for scan_gap_cluster_extractor. Points go in through a queue-fed
// driver. A monitor compares every cluster word that comes out with a queue of
// predicted cluster words. The prediction is worked out when a point is accepted.
module tb_scan_gap_cluster_extractor;
  import sgce_pkg::*;

  // One scan point as the driver offers it.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } point_t;

  // One closed segment that survived the size and radius tests.
  typedef struct {
    longint          cx;
    longint          cy;
    longint unsigned rad;
    int              cnt;
  } found_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = REG_GAP;
  logic [15:0] cfg_wdata = '0;

  sgce_in_if  in_pt ();
  sgce_out_if out_cl ();

  scan_gap_cluster_extractor i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pt    (in_pt),
    .out_cl   (out_cl),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Register shadows, loaded with the reset defaults.
  int unsigned gap_reg  = 300;
  int unsigned minp_reg = 3;
  int unsigned maxc_reg = 10;
  int unsigned maxr_reg = 0;

  // Scan state of the prediction.
  longint   seg_x[$];
  longint   seg_y[$];
  longint   prev_x = 0;
  longint   prev_y = 0;
  int       scan_pts = 0;
  found_t   found_q[$];
  bit       dropped = 1'b0;

  point_t   pend_q[$];
  res_t     cluster_q[$];
  point_t   cur_pt;
  int       errors = 0;

  int       src_idle = 34;
  int       snk_idle = 77;
  bit       src_pause = 1'b0;
  int       snk_hold_left = 0;
  bit       hold_tok = 1'b0;
  bit       hold_seen = 1'b0;

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 20; b >= 0; b--) begin
      c = r + (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // Turns the buffered segment into a cluster if it is long enough, tight
  // enough, and the cluster table still has room.
  task automatic seal_segment();
    int n;
    int need;
    longint sx, sy, cx, cy, dx, dy;
    longint unsigned d2, best, rad;
    found_t f;
    n = seg_x.size();
    need = (minp_reg == 0) ? 1 : minp_reg;
    sx = 0;
    sy = 0;
    best = 0;
    if (n != 0 && n >= need) begin
      foreach (seg_x[i]) begin
        sx += seg_x[i];
        sy += seg_y[i];
      end
      cx = sx / n;
      cy = sy / n;
      foreach (seg_x[i]) begin
        dx = seg_x[i] - cx;
        dy = seg_y[i] - cy;
        d2 = dx * dx + dy * dy;
        if (d2 > best) best = d2;
      end
      rad = floor_sqrt(best);
      if (!(maxr_reg != 0 && rad > maxr_reg)) begin
        if (found_q.size() >= FOUND_MAX) begin
          dropped = 1'b1;
        end else begin
          f.cx = cx;
          f.cy = cy;
          f.rad = rad;
          f.cnt = n;
          found_q.insert(found_q.size(), f);
        end
      end
    end
    seg_x.delete();
    seg_y.delete();
  endtask

  function automatic res_t make_word(found_t f, bit last);
    res_t r;
    r.valid = 1'b1;
    r.cx = f.cx[15:0];
    r.cy = f.cy[15:0];
    r.rad = f.rad[RAD_W-1:0];
    r.cnt = f.cnt[PCNT_W-1:0];
    r.last = last;
    r.ovf = dropped;
    return r;
  endfunction

  // Closes the scan and queues its cluster words. When the cap applies, the
  // largest clusters go first and the earlier cluster wins a tie.
  task automatic finish_scan();
    int cap;
    int pick;
    bit used[FOUND_MAX];
    res_t r;
    seal_segment();
    cap = (maxc_reg == 0) ? 1 : maxc_reg;
    if (found_q.size() == 0) begin
      r = '0;
      r.last = 1'b1;
      r.ovf = dropped;
      cluster_q.insert(cluster_q.size(), r);
    end else if (found_q.size() <= cap) begin
      foreach (found_q[k])
        cluster_q.insert(cluster_q.size(), make_word(found_q[k], k == found_q.size() - 1));
    end else begin
      foreach (used[i]) used[i] = 1'b0;
      for (int k = 0; k < cap; k++) begin
        pick = -1;
        foreach (found_q[i]) begin
          if (!used[i] && (pick < 0 || found_q[i].cnt > found_q[pick].cnt)) pick = i;
        end
        used[pick] = 1'b1;
        cluster_q.insert(cluster_q.size(), make_word(found_q[pick], k == cap - 1));
      end
    end
    found_q.delete();
    scan_pts = 0;
    prev_x = 0;
    prev_y = 0;
    dropped = 1'b0;
  endtask

  task automatic take_point(point_t p);
    longint dx, dy;
    longint unsigned d2, g2;
    if (scan_pts != 0) begin
      dx = longint'(p.x) - prev_x;
      dy = longint'(p.y) - prev_y;
      d2 = dx * dx + dy * dy;
      g2 = longint'(gap_reg) * gap_reg;
      if (d2 > g2) seal_segment();
    end
    if (seg_x.size() < POINTS_MAX) begin
      seg_x.insert(seg_x.size(), p.x);
      seg_y.insert(seg_y.size(), p.y);
    end else begin
      dropped = 1'b1;
    end
    prev_x = p.x;
    prev_y = p.y;
    scan_pts++;
    if (p.last) finish_scan();
  endtask

  // Driver: a word stays on the bus until it is taken. The prediction runs at
  // the edge that accepts it.
  always @(posedge clk) begin
    logic give;
    if (!rst_n) begin
      in_pt.valid <= 1'b0;
      in_pt.x_mm <= '0;
      in_pt.y_mm <= '0;
      in_pt.last_point <= 1'b0;
    end else begin
      if (in_pt.valid && in_pt.ready) take_point(cur_pt);
      if (!in_pt.valid || in_pt.ready) begin
        give = pend_q.size() > 0 && !src_pause && $urandom_range(99) >= src_idle;
        if (give) begin
          cur_pt = pend_q.pop_front();
          in_pt.x_mm <= cur_pt.x;
          in_pt.y_mm <= cur_pt.y;
          in_pt.last_point <= cur_pt.last;
          in_pt.valid <= 1'b1;
        end else begin
          in_pt.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by a toggle of hold_tok, counted down here
  // and obeyed by the monitor.
  always @(posedge clk) begin
    if (hold_tok != hold_seen) begin
      hold_seen <= hold_tok;
      snk_hold_left <= 600;
    end else if (snk_hold_left > 0) begin
      snk_hold_left <= snk_hold_left - 1;
    end
  end

  // Monitor: every accepted word is checked against the oldest prediction.
  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      out_cl.ready <= 1'b0;
    end else begin
      if (out_cl.valid && out_cl.ready) begin
        if (cluster_q.size() == 0) begin
          $error("cluster word with nothing expected");
          errors++;
        end else begin
          e = cluster_q.pop_front();
          if (out_cl.cluster_valid !== e.valid) begin
            $error("cluster_valid: expected %0d, got %0d", e.valid, out_cl.cluster_valid);
            errors++;
          end
          if (out_cl.center_x_mm !== e.cx) begin
            $error("center_x_mm: expected %0d, got %0d", e.cx, out_cl.center_x_mm);
            errors++;
          end
          if (out_cl.center_y_mm !== e.cy) begin
            $error("center_y_mm: expected %0d, got %0d", e.cy, out_cl.center_y_mm);
            errors++;
          end
          if (out_cl.radius_mm !== e.rad) begin
            $error("radius_mm: expected %0d, got %0d", e.rad, out_cl.radius_mm);
            errors++;
          end
          if (out_cl.point_count !== e.cnt) begin
            $error("point_count: expected %0d, got %0d", e.cnt, out_cl.point_count);
            errors++;
          end
          if (out_cl.last_cluster !== e.last) begin
            $error("last_cluster: expected %0d, got %0d", e.last, out_cl.last_cluster);
            errors++;
          end
          if (out_cl.overflow !== e.ovf) begin
            $error("overflow: expected %0d, got %0d", e.ovf, out_cl.overflow);
            errors++;
          end
        end
      end
      out_cl.ready <= (snk_hold_left == 0) && ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic add_point(int x, int y, bit last);
    point_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.last = last;
    pend_q.insert(pend_q.size(), p);
  endtask

  // Builds one scan of compact segments with random content and some stray
  // full-range points; the final point carries the end-of-scan mark.
  task automatic random_scan(int spread, int maxlen, output int added);
    int nseg, len, cx, cy;
    point_t p;
    point_t pts[$];
    nseg = $urandom_range(1, 8);
    for (int s = 0; s < nseg; s++) begin
      if ($urandom_range(9) == 0) begin
        p.x = 16'($urandom);
        p.y = 16'($urandom);
        pts.insert(pts.size(), p);
      end else begin
        cx = $urandom_range(1, 8) == 1 ? ($urandom_range(1) ? 32767 - spread : -32768 + spread)
                                       : int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
        len = $urandom_range(1, maxlen);
        for (int i = 0; i < len; i++) begin
          p.x = 16'(cx + int'($urandom_range(2 * spread)) - spread);
          p.y = 16'(cy + int'($urandom_range(2 * spread)) - spread);
          pts.insert(pts.size(), p);
        end
      end
    end
    foreach (pts[i]) add_point(pts[i].x, pts[i].y, i == pts.size() - 1);
    added = pts.size();
  endtask

  task automatic random_phase(int n_items, int spread, int maxlen);
    int done, got;
    done = 0;
    while (done < n_items) begin
      random_scan(spread, maxlen, got);
      done += got;
    end
  endtask

  // Waits until every queued point is taken and every cluster word has come,
  // then lets the block settle before registers are touched.
  task automatic drain();
    wait (pend_q.size() == 0 && !in_pt.valid && cluster_q.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAP:  gap_reg = val & 16'hFFFF;
      REG_MINP: minp_reg = val & 12'hFFF;
      REG_MAXC: maxc_reg = val & 7'h7F;
      REG_MAXR: maxr_reg = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned g, int unsigned mp, int unsigned mc, int unsigned mr);
    set_reg(REG_GAP, g);
    set_reg(REG_MINP, mp);
    set_reg(REG_MAXC, mc);
    set_reg(REG_MAXR, mr);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset defaults. It covers a simple cluster, a
    // scan with no cluster, full-scale coordinates on both corners, and more
    // segments than the cluster cap allows.
    add_point(0, 0, 0);
    add_point(100, 0, 0);
    add_point(200, -7, 1);
    add_point(5, 5, 1);
    add_point(-32768, -32768, 0);
    add_point(-32768, -32768, 0);
    add_point(-32768, -32767, 0);
    add_point(32767, 32767, 0);
    add_point(32767, 32767, 0);
    add_point(32767, 32766, 1);
    for (int s = 0; s < 12; s++) begin
      for (int i = 0; i < 3 + (s % 3); i++) add_point(s * 2000, i * 10, 0);
    end
    add_point(-9000, 0, 1);
    drain();

    // Tight radius limit and a cap of three; the receiver then holds off for a
    // long stretch while the sender keeps offering short scans.
    set_all(1000, 2, 3, 150);
    random_phase(25, 120, 6);
    drain();
    @(posedge clk);
    hold_tok <= ~hold_tok;
    random_phase(15, 60, 4);
    random_phase(10, 120, 5);
    // The sender stops until every result of the work so far has arrived.
    wait (pend_q.size() == 0 && !in_pt.valid);
    src_pause <= 1'b1;
    random_phase(10, 80, 4);
    wait (cluster_q.size() == 0);
    @(posedge clk);
    src_pause <= 1'b0;
    drain();

    // Largest gap and radius, smallest size, widest cap; the idling swaps.
    src_idle = 77;
    snk_idle = 34;
    set_all(65535, 1, 64, 65535);
    random_phase(35, 2000, 6);
    drain();

    // Zero gap, zero size and a zero cap, which acts as a cap of one.
    set_all(0, 0, 0, 0);
    random_phase(25, 1, 4);
    drain();

    // A size limit above the store, so that no segment can qualify.
    set_all(200, 4095, 5, 0);
    random_phase(15, 50, 6);
    drain();

    // No idling from here on. A full cluster table first.
    src_idle = 0;
    snk_idle = 0;
    set_all(20, 1, 64, 0);
    for (int i = 0; i < 66; i++) add_point(i * 100 - 3000, 0, i == 65);
    drain();
    random_phase(15, 8, 5);
    drain();

    set_all(500, 2, 2, 1000);
    random_phase(25, 300, 7);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### scan_gap_cluster_extractor.f
hdl/sgce_pkg.sv
hdl/sgce_if.sv
hdl/sgce_front.sv
hdl/sgce_fifo.sv
hdl/sgce_back.sv
hdl/scan_gap_cluster_extractor.sv
sim/tb_scan_gap_cluster_extractor.sv
